// File: rtl/ghst_pkg.sv
`default_nettype none

package ghst_pkg;

  // Default table geometry
  localparam int SLOTS_DEF    = 256;
  localparam int GEN_BITS_DEF = 16;

  // Command codes
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;
  localparam logic [1:0] CMD_GET     = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Stored payload of one slot
  typedef struct packed {
    logic [15:0] pipeline_id;
    logic [31:0] material_word;
  } pay_t;

  localparam int PAY_W = $bits(pay_t);

  // Input word
  typedef struct packed {
    logic [1:0]  cmd;
    logic        handle_valid;
    logic [7:0]  handle_index;
    logic [15:0] handle_generation;
    logic [15:0] pipeline_id;
    logic [31:0] material_word;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [15:0] out_generation;
    logic [15:0] out_pipeline_id;
    logic [31:0] out_material_word;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/ghst_ram.sv
`default_nettype none

module ghst_ram #(
  parameter int DEPTH = ghst_pkg::SLOTS_DEF,
  parameter int WIDTH = $clog2(ghst_pkg::SLOTS_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/generational_handle_slot_table_core.sv
`default_nettype none

// Generational handle slot table. Each word on the in_ channel is one command: create
// (store a payload in a freed or fresh slot and return its handle), destroy (retire a
// live handle onto the pending list), flush (bump the generation of every pending slot
// and move it to the free stack) or get (return the payload of a live, matching handle).
// Every command gives exactly one result word. One command is worked at a time; the next
// word is accepted as soon as the previous result is registered, even while that result
// still waits on out_ready. Destroy and get read the slot entry, then finish in S_EXEC;
// create of a never-used slot goes straight to S_EXEC, create that reuses a freed slot
// first pops the free stack (S_POP), and flush takes each pending slot through S_FL_LIST
// and S_FL_ENT. All memory reads are registered. No clearing pass follows reset: slots at
// or above the used count fail the handle check, so their entries need no initial value.
module generational_handle_slot_table_core #(
  parameter int SLOTS    = ghst_pkg::SLOTS_DEF,
  parameter int GEN_BITS = ghst_pkg::GEN_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ghst_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ghst_pkg::out_word_t       out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int ENT_W = 1 + GEN_BITS + ghst_pkg::PAY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_EXEC,
    S_FL_LIST,
    S_FL_ENT
  } state_t;

  state_t               state_r, state_nxt;
  ghst_pkg::in_word_t   item_r, item_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 full_r, full_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     pend_r, pend_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ghst_pkg::out_word_t  out_data_r, out_data_nxt;

  // Memory ports
  logic                 ent_wr_en, ent_rd_en;
  logic [IDX_W-1:0]     ent_wr_addr, ent_rd_addr;
  logic [ENT_W-1:0]     ent_wr_data, ent_rd_data;
  logic                 fs_wr_en, fs_rd_en;
  logic [IDX_W-1:0]     fs_wr_addr, fs_rd_addr, fs_wr_data, fs_rd_data;
  logic                 pl_wr_en, pl_rd_en;
  logic [IDX_W-1:0]     pl_wr_addr, pl_rd_addr, pl_wr_data, pl_rd_data;

  // Entry fields and derived values
  logic                 rd_alive;
  logic [GEN_BITS-1:0]  rd_gen;
  ghst_pkg::pay_t       rd_pay;
  ghst_pkg::pay_t       new_pay;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [GEN_BITS-1:0]  gen_new;
  logic [IDX_W-1:0]     hidx;
  logic [1:0]           chk_st;
  logic                 out_load;

  assign rd_alive = ent_rd_data[ENT_W-1];
  assign rd_gen   = ent_rd_data[ENT_W-2 -: GEN_BITS];
  assign rd_pay   = ghst_pkg::pay_t'(ent_rd_data[ghst_pkg::PAY_W-1:0]);
  assign new_pay  = '{pipeline_id: item_r.pipeline_id, material_word: item_r.material_word};
  assign gen_inc  = rd_gen + GEN_BITS'(1);
  assign gen_new  = fresh_r ? GEN_BITS'(1) : gen_inc;
  assign hidx     = IDX_W'(item_r.handle_index);
  assign out_load = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Check the held handle against the entry just read
  always_comb begin
    if (!item_r.handle_valid) begin
      chk_st = ghst_pkg::ST_NULL;
    end else if (CMP_W'(item_r.handle_index) >= CMP_W'(used_r)) begin
      chk_st = ghst_pkg::ST_BAD;
    end else if ((16'(rd_gen) != item_r.handle_generation) || !rd_alive) begin
      chk_st = ghst_pkg::ST_BAD;
    end else begin
      chk_st = ghst_pkg::ST_OK;
    end
  end

  // Sequence each command through its memory reads and the write-back
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    slot_nxt      = slot_r;
    fresh_nxt     = fresh_r;
    full_nxt      = full_r;
    used_nxt      = used_r;
    free_nxt      = free_r;
    pend_nxt      = pend_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ent_wr_en     = 1'b0;
    ent_wr_addr   = slot_r;
    ent_wr_data   = '0;
    ent_rd_en     = 1'b0;
    ent_rd_addr   = slot_r;
    fs_wr_en      = 1'b0;
    fs_wr_addr    = IDX_W'(free_r);
    fs_wr_data    = slot_r;
    fs_rd_en      = 1'b0;
    fs_rd_addr    = IDX_W'(free_r - CNT_W'(1));
    pl_wr_en      = 1'b0;
    pl_wr_addr    = IDX_W'(pend_r);
    pl_wr_data    = hidx;
    pl_rd_en      = 1'b0;
    pl_rd_addr    = IDX_W'(ptr_r + CNT_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          fresh_nxt = 1'b0;
          full_nxt  = 1'b0;
          unique case (in_data.cmd) inside
            ghst_pkg::CMD_CREATE: begin
              if (free_r != '0) begin
                // pop the most recently freed slot
                fs_rd_en  = 1'b1;
                state_nxt = S_POP;
              end else if (used_r != CNT_W'(SLOTS)) begin
                // grow into a never-used slot, which starts at generation one
                slot_nxt  = IDX_W'(used_r);
                fresh_nxt = 1'b1;
                state_nxt = S_EXEC;
              end else begin
                full_nxt  = 1'b1;
                state_nxt = S_EXEC;
              end
            end
            ghst_pkg::CMD_DESTROY, ghst_pkg::CMD_GET: begin
              ent_rd_en   = 1'b1;
              ent_rd_addr = IDX_W'(in_data.handle_index);
              state_nxt   = S_EXEC;
            end
            ghst_pkg::CMD_FLUSH: begin
              if (pend_r != '0) begin
                pl_rd_en   = 1'b1;
                pl_rd_addr = '0;
                ptr_nxt    = '0;
                state_nxt  = S_FL_LIST;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            default: state_nxt = S_EXEC;
          endcase
        end
      end

      S_POP: begin
        slot_nxt    = fs_rd_data;
        ent_rd_en   = 1'b1;
        ent_rd_addr = fs_rd_data;
        state_nxt   = S_EXEC;
      end

      S_FL_LIST: begin
        slot_nxt    = pl_rd_data;
        ent_rd_en   = 1'b1;
        ent_rd_addr = pl_rd_data;
        state_nxt   = S_FL_ENT;
      end

      S_FL_ENT: begin
        // bump the generation and push the slot on the free stack
        ent_wr_en   = 1'b1;
        ent_wr_data = {rd_alive, gen_inc, rd_pay};
        if (free_r != CNT_W'(SLOTS)) begin
          fs_wr_en = 1'b1;
          free_nxt = free_r + CNT_W'(1);
        end
        ptr_nxt = ptr_r + CNT_W'(1);
        if ((ptr_r + CNT_W'(1)) == pend_r) begin
          state_nxt = S_EXEC;
        end else begin
          pl_rd_en  = 1'b1;
          state_nxt = S_FL_LIST;
        end
      end

      S_EXEC: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          unique case (item_r.cmd)
            ghst_pkg::CMD_CREATE: begin
              if (full_r) begin
                out_data_nxt.status = ghst_pkg::ST_FULL;
              end else begin
                ent_wr_en   = 1'b1;
                ent_wr_data = {1'b1, gen_new, new_pay};
                if (fresh_r) begin
                  used_nxt = used_r + CNT_W'(1);
                end else begin
                  free_nxt = free_r - CNT_W'(1);
                end
                out_data_nxt.status         = ghst_pkg::ST_OK;
                out_data_nxt.out_index      = 8'(slot_r);
                out_data_nxt.out_generation = 16'(gen_new);
              end
            end
            ghst_pkg::CMD_DESTROY: begin
              out_data_nxt.status = chk_st;
              if (chk_st == ghst_pkg::ST_OK) begin
                ent_wr_en   = 1'b1;
                ent_wr_addr = hidx;
                ent_wr_data = {1'b0, rd_gen, rd_pay};
                if (pend_r != CNT_W'(SLOTS)) begin
                  pl_wr_en = 1'b1;
                  pend_nxt = pend_r + CNT_W'(1);
                end
              end
            end
            ghst_pkg::CMD_FLUSH: begin
              out_data_nxt.status = ghst_pkg::ST_OK;
              pend_nxt            = '0;
            end
            ghst_pkg::CMD_GET: begin
              out_data_nxt.status = chk_st;
              if (chk_st == ghst_pkg::ST_OK) begin
                out_data_nxt.out_pipeline_id   = rd_pay.pipeline_id;
                out_data_nxt.out_material_word = rd_pay.material_word;
              end
            end
            default: out_data_nxt.status = ghst_pkg::ST_OK;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, counts and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_r      <= '0;
      pend_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      pend_r      <= pend_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    fresh_r    <= fresh_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Slot entries: alive bit, generation, payload
  ghst_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

  // Free stack of reusable slot indexes
  ghst_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IDX_W)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (fs_wr_en),
    .wr_addr (fs_wr_addr),
    .wr_data (fs_wr_data),
    .rd_en   (fs_rd_en),
    .rd_addr (fs_rd_addr),
    .rd_data (fs_rd_data)
  );

  // Pending list of destroyed slot indexes
  ghst_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IDX_W)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (pl_wr_en),
    .wr_addr (pl_wr_addr),
    .wr_data (pl_wr_data),
    .rd_en   (pl_rd_en),
    .rd_addr (pl_rd_addr),
    .rd_data (pl_rd_data)
  );

  // Every used slot is alive, pending or free, never two of these at once
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (({1'b0, free_r} + {1'b0, pend_r}) <= {1'b0, used_r}))
    else $error("free and pending counts exceed used count");

  // Entry memory is never read and written in the same cycle
  a_ent_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ent_wr_en && ent_rd_en))
    else $error("entry memory read and write collide");

  // No write-back while a new command can enter
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(ent_wr_en || fs_wr_en || pl_wr_en))
    else $error("memory write while idle");

  // A finished flush leaves the pending list empty
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (item_r.cmd == ghst_pkg::CMD_FLUSH)) |=> (pend_r == '0))
    else $error("pending list not empty after flush");

endmodule

`default_nettype wire
